[hw/rtl/cbct_pkg.sv]
// Shared constants, register codes and types for the color blob centroid tracker.
`timescale 1ns / 1ps

package cbct_pkg;

    // Frame geometry limits and counter widths
    localparam int MAX_COLS   = 2048;
    localparam int MAX_ROWS   = 2048;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);

    // Register widths
    localparam int SIZE_W     = 12;
    localparam int LEVEL_W    = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    // Accumulator widths: sum of positions and marker count per frame
    localparam int SUM_W      = 33;
    localparam int CNT_W      = 23;

    // Centroid field width; also the quotient bits the divider produces
    localparam int POS_W      = 12;

    // Pixel channel width
    localparam int PIX_W      = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIXELS  = 2'd3;

    // Register reset values
    localparam logic [SIZE_W-1:0]  RST_FRAME_COLS  = 12'd1000;
    localparam logic [SIZE_W-1:0]  RST_FRAME_ROWS  = 12'd750;
    localparam logic [LEVEL_W-1:0] RST_GREEN_FLOOR = 8'd100;
    localparam logic [LEVEL_W-1:0] RST_MIN_PIXELS  = 8'd3;

    // Marker pixel replacement color and the "not found" centroid code
    localparam logic [PIX_W-1:0] MARK_RED      = 8'd255;
    localparam logic [POS_W-1:0] CENTROID_NONE = 12'hFFF;

    // Ratio test factors, scaled by ten: 10*g > 13*b and 10*g > 15*r
    localparam logic [POS_W-1:0] K_GREEN = 12'd10;
    localparam logic [POS_W-1:0] K_BLUE  = 12'd13;
    localparam logic [POS_W-1:0] K_RED   = 12'd15;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/cbct_div.sv]
// Shared restoring divider: one quotient bit per cycle, POS_W bits per division.
`timescale 1ns / 1ps

module cbct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cbct_pkg::SUM_W-1:0]    i_dividend,
    input  logic [cbct_pkg::CNT_W-1:0]    i_divisor,
    output logic [cbct_pkg::POS_W-1:0]    o_quotient,
    output cbct_pkg::t_div_stat           o_stat
);

    localparam int CNT_BITS = $clog2(cbct_pkg::POS_W + 1);

    // Quotient is known to fit POS_W bits (mean of positions below MAX_COLS),
    // so the upper dividend bits are already a valid partial remainder.
    logic [cbct_pkg::CNT_W-1:0]  r_rem;
    logic [cbct_pkg::POS_W-1:0]  r_low;
    logic [cbct_pkg::POS_W-1:0]  r_quo;
    logic [cbct_pkg::CNT_W-1:0]  r_dvs;
    logic [CNT_BITS-1:0]         r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [cbct_pkg::CNT_W:0]    w_part;
    logic [cbct_pkg::CNT_W:0]    w_diff;
    logic                        w_ge;
    logic [cbct_pkg::CNT_W-1:0]  n_rem;

    // One trial subtraction per cycle
    always_comb begin
        w_part = {r_rem, r_low[cbct_pkg::POS_W-1]};
        w_ge   = w_part >= {1'b0, r_dvs};
        w_diff = w_part - {1'b0, r_dvs};
        n_rem  = w_ge ? w_diff[cbct_pkg::CNT_W-1:0] : w_part[cbct_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= cbct_pkg::CNT_W'(i_dividend[cbct_pkg::SUM_W-1:cbct_pkg::POS_W]);
                r_low  <= i_dividend[cbct_pkg::POS_W-1:0];
                r_dvs  <= i_divisor;
                r_quo  <= '0;
                r_cnt  <= CNT_BITS'(cbct_pkg::POS_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= {r_low[cbct_pkg::POS_W-2:0], 1'b0};
                r_quo <= {r_quo[cbct_pkg::POS_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[hw/rtl/color_blob_centroid_tracker.sv]
// Top level: marker color test, position sums and frame-end centroid reporting.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one BGR pixel per transfer in raster order; the block counts
//   column and row itself from frame_cols and frame_rows. m_axis returns one
//   pixel per input pixel, marker pixels recolored to pure red. tlast marks the
//   frame's last pixel; on that item tuser is the found flag and the centroid
//   fields hold the mean marker column and row (-1,-1 when not found).
//   Ordinary pixels, and a frame end without a centroid, land in the output
//   register in the cycle after the transfer; a new pixel is taken every
//   cycle while the receiver keeps up.
//   A frame end that reports a centroid runs two divisions on one shared
//   restoring divider, one quotient bit per cycle and 12 bits each; that
//   pixel appears once both are done, and s_axis_tready stays low meanwhile.
//   When the receiver stalls, the result holds in the output register and
//   s_axis_tready drops until it is taken.
//   Reset (synchronous, active low) clears counters and sums, empties the
//   output register and loads the register defaults. Configuration writes
//   take effect at once and never clear the counters.
module color_blob_centroid_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [cbct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbct_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Pixel input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // in_blue, in_green, in_red
    // Pixel and centroid output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,  // out_blue, out_green, out_red,
                                                             // centroid_x, centroid_y
    output logic                              m_axis_tlast,  // frame_done
    output logic                              m_axis_tuser   // found
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY
    } t_state;

    t_state                          r_state;

    // Configuration registers
    logic [cbct_pkg::SIZE_W-1:0]     r_frame_cols;
    logic [cbct_pkg::SIZE_W-1:0]     r_frame_rows;
    logic [cbct_pkg::LEVEL_W-1:0]    r_green_floor;
    logic [cbct_pkg::LEVEL_W-1:0]    r_min_pixels;

    // Position counters and accumulators
    logic [cbct_pkg::COL_W-1:0]      r_col;
    logic [cbct_pkg::ROW_W-1:0]      r_row;
    logic [cbct_pkg::SUM_W-1:0]      r_sum_cols;
    logic [cbct_pkg::SUM_W-1:0]      r_sum_rows;
    logic [cbct_pkg::CNT_W-1:0]      r_marks;

    // Output register
    logic                            r_out_valid;
    logic [cbct_pkg::PIX_W-1:0]      r_out_blue;
    logic [cbct_pkg::PIX_W-1:0]      r_out_green;
    logic [cbct_pkg::PIX_W-1:0]      r_out_red;
    logic                            r_out_last;
    logic                            r_out_found;
    logic [cbct_pkg::POS_W-1:0]      r_out_cx;
    logic [cbct_pkg::POS_W-1:0]      r_out_cy;

    logic                            r_div_start;

    logic [cbct_pkg::PIX_W-1:0]      w_blue;
    logic [cbct_pkg::PIX_W-1:0]      w_green;
    logic [cbct_pkg::PIX_W-1:0]      w_red;
    logic [cbct_pkg::SIZE_W-1:0]     w_cols;
    logic [cbct_pkg::SIZE_W-1:0]     w_rows;
    logic                            w_last_col;
    logic                            w_last_row;
    logic                            w_frame_end;
    logic                            w_marker;
    logic [cbct_pkg::SUM_W-1:0]      w_sum_cols;
    logic [cbct_pkg::SUM_W-1:0]      w_sum_rows;
    logic [cbct_pkg::CNT_W-1:0]      w_marks;
    logic                            w_found;
    logic                            w_accept;
    logic [cbct_pkg::SUM_W-1:0]      w_dividend;
    logic [cbct_pkg::POS_W-1:0]      w_quotient;
    cbct_pkg::t_div_stat             w_div_stat;

    assign w_blue  = s_axis_tdata[7:0];
    assign w_green = s_axis_tdata[15:8];
    assign w_red   = s_axis_tdata[23:16];

    // Frame size with zero read as one and oversize clipped
    always_comb begin
        if (r_frame_cols == '0) begin
            w_cols = cbct_pkg::SIZE_W'(1);
        end else if (r_frame_cols > cbct_pkg::SIZE_W'(cbct_pkg::MAX_COLS)) begin
            w_cols = cbct_pkg::SIZE_W'(cbct_pkg::MAX_COLS);
        end else begin
            w_cols = r_frame_cols;
        end
        if (r_frame_rows == '0) begin
            w_rows = cbct_pkg::SIZE_W'(1);
        end else if (r_frame_rows > cbct_pkg::SIZE_W'(cbct_pkg::MAX_ROWS)) begin
            w_rows = cbct_pkg::SIZE_W'(cbct_pkg::MAX_ROWS);
        end else begin
            w_rows = r_frame_rows;
        end
    end

    // Row and frame end; a counter past a shrunk size counts as at the end
    assign w_last_col  = cbct_pkg::SIZE_W'(r_col) >= (w_cols - cbct_pkg::SIZE_W'(1));
    assign w_last_row  = cbct_pkg::SIZE_W'(r_row) >= (w_rows - cbct_pkg::SIZE_W'(1));
    assign w_frame_end = w_last_col && w_last_row;

    // Marker test: green dominates blue by 1.3 and red by 1.5, above the floor
    assign w_marker =
        (cbct_pkg::POS_W'(w_green) * cbct_pkg::K_GREEN > cbct_pkg::POS_W'(w_blue) * cbct_pkg::K_BLUE)
        && (cbct_pkg::POS_W'(w_green) * cbct_pkg::K_GREEN > cbct_pkg::POS_W'(w_red) * cbct_pkg::K_RED)
        && (w_green > r_green_floor);

    // Accumulators including the current pixel
    assign w_sum_cols = w_marker ? r_sum_cols + cbct_pkg::SUM_W'(r_col) : r_sum_cols;
    assign w_sum_rows = w_marker ? r_sum_rows + cbct_pkg::SUM_W'(r_row) : r_sum_rows;
    assign w_marks    = w_marker ? r_marks + cbct_pkg::CNT_W'(1) : r_marks;
    assign w_found    = (w_marks != '0) && (w_marks >= cbct_pkg::CNT_W'(r_min_pixels));

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Shared divider: column sum first, then row sum
    assign w_dividend = (r_state == S_DIVX) ? r_sum_cols : r_sum_rows;

    cbct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_marks),
        .o_quotient (w_quotient),
        .o_stat     (w_div_stat)
    );

    // Sequencer, counters, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_cols  <= cbct_pkg::RST_FRAME_COLS;
            r_frame_rows  <= cbct_pkg::RST_FRAME_ROWS;
            r_green_floor <= cbct_pkg::RST_GREEN_FLOOR;
            r_min_pixels  <= cbct_pkg::RST_MIN_PIXELS;
            r_col         <= '0;
            r_row         <= '0;
            r_sum_cols    <= '0;
            r_sum_rows    <= '0;
            r_marks       <= '0;
            r_out_valid   <= 1'b0;
            r_div_start   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbct_pkg::CFG_FRAME_COLS:  r_frame_cols  <= i_cfg_wdata;
                    cbct_pkg::CFG_FRAME_ROWS:  r_frame_rows  <= i_cfg_wdata;
                    cbct_pkg::CFG_GREEN_FLOOR: r_green_floor <= i_cfg_wdata[cbct_pkg::LEVEL_W-1:0];
                    cbct_pkg::CFG_MIN_PIXELS:  r_min_pixels  <= i_cfg_wdata[cbct_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end

            r_div_start <= 1'b0;
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        // Pass or recolor the pixel
                        r_out_blue  <= w_marker ? '0 : w_blue;
                        r_out_green <= w_marker ? '0 : w_green;
                        r_out_red   <= w_marker ? cbct_pkg::MARK_RED : w_red;
                        r_out_last  <= w_frame_end;
                        r_out_found <= 1'b0;
                        r_out_cx    <= '0;
                        r_out_cy    <= '0;
                        r_out_valid <= 1'b1;

                        // Raster position
                        if (w_last_col) begin
                            r_col <= '0;
                            r_row <= w_last_row ? '0 : r_row + cbct_pkg::ROW_W'(1);
                        end else begin
                            r_col <= r_col + cbct_pkg::COL_W'(1);
                        end

                        if (!w_frame_end) begin
                            r_sum_cols <= w_sum_cols;
                            r_sum_rows <= w_sum_rows;
                            r_marks    <= w_marks;
                        end else if (w_found) begin
                            // Hold the sums for the divider; result waits
                            r_sum_cols  <= w_sum_cols;
                            r_sum_rows  <= w_sum_rows;
                            r_marks     <= w_marks;
                            r_out_valid <= 1'b0;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIVX;
                        end else begin
                            r_out_cx   <= cbct_pkg::CENTROID_NONE;
                            r_out_cy   <= cbct_pkg::CENTROID_NONE;
                            r_sum_cols <= '0;
                            r_sum_rows <= '0;
                            r_marks    <= '0;
                        end
                    end
                end
                S_DIVX: begin
                    if (w_div_stat.done) begin
                        r_out_cx    <= w_quotient;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_stat.done) begin
                        r_out_cy    <= w_quotient;
                        r_out_found <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_sum_cols  <= '0;
                        r_sum_rows  <= '0;
                        r_marks     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cy, r_out_cx, r_out_red, r_out_green, r_out_blue};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_found;

`ifndef SYNTH
    // No result is offered while a centroid is being computed
    a_no_out_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("output valid during centroid division");

    // The divider only runs on behalf of a frame end
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_stat.busy || w_div_stat.done) |-> (r_state != S_IDLE))
        else $error("divider active outside division states");

    // Only a frame end carries centroid information
    a_mid_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (!m_axis_tuser && r_out_cx == '0 && r_out_cy == '0))
        else $error("centroid data on a pixel that is not a frame end");

    // A second division start follows the first result in the next cycle
    a_div_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX && w_div_stat.done) |=> (r_div_start && r_state == S_DIVY))
        else $error("row division not started after column division");
`endif

endmodule

[tb/sv/tb_top.sv]
// Testbench for the color blob centroid tracker: marker recoloring and frame-end centroids.
`timescale 1ns / 1ps

module tb_top;

    // One expected output transfer
    typedef struct packed {
        logic [cbct_pkg::PIX_W-1:0] blue;
        logic [cbct_pkg::PIX_W-1:0] green;
        logic [cbct_pkg::PIX_W-1:0] red;
        logic                       frame_done;
        logic                       found;
        logic [cbct_pkg::POS_W-1:0] cent_x;
        logic [cbct_pkg::POS_W-1:0] cent_y;
    } t_px_out;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [cbct_pkg::CFG_IDX_W-1:0] i_cfg_index   = cbct_pkg::CFG_FRAME_COLS;
    logic [cbct_pkg::CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata  = '0;   // in_blue, in_green, in_red
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [47:0]                    m_axis_tdata;         // out_blue, out_green, out_red,
                                                          // centroid_x, centroid_y
    logic                           m_axis_tlast;         // frame_done
    logic                           m_axis_tuser;         // found

    // Tracker image: register copies, raster position and marker sums
    int unsigned     trk_cols, trk_rows, trk_floor, trk_min;
    int unsigned     col_pos, row_pos, mark_cnt;
    longint unsigned col_sum, row_sum;
    t_px_out         expected_px[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int n_pixels = 0, n_frames = 0, n_found = 0, n_markers = 0;

    color_blob_centroid_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Advance the tracker image by one pixel and return the output it should produce
    function automatic t_px_out track_pixel(input int unsigned b, g, r);
        t_px_out     res;
        int unsigned cols, rows;
        bit          last_col, last_row, marker;
        cols = (trk_cols == 0) ? 1 : ((trk_cols > cbct_pkg::MAX_COLS) ? cbct_pkg::MAX_COLS
                                                                       : trk_cols);
        rows = (trk_rows == 0) ? 1 : ((trk_rows > cbct_pkg::MAX_ROWS) ? cbct_pkg::MAX_ROWS
                                                                       : trk_rows);
        // counters past a shrunk edge count as sitting on it
        last_col = (col_pos >= cols - 1);
        last_row = (row_pos >= rows - 1);
        marker   = (10 * g > 13 * b) && (10 * g > 15 * r) && (g > trk_floor);
        res = '0;
        res.blue  = cbct_pkg::PIX_W'(b);
        res.green = cbct_pkg::PIX_W'(g);
        res.red   = cbct_pkg::PIX_W'(r);
        n_pixels++;
        if (marker) begin
            col_sum += col_pos;
            row_sum += row_pos;
            mark_cnt++;
            n_markers++;
            res.blue  = '0;
            res.green = '0;
            res.red   = cbct_pkg::MARK_RED;
        end
        if (last_col && last_row) begin
            res.frame_done = 1'b1;
            n_frames++;
            // an empty frame never reports, even with a zero minimum
            if (mark_cnt > 0 && mark_cnt >= trk_min) begin
                res.found  = 1'b1;
                res.cent_x = cbct_pkg::POS_W'(col_sum / mark_cnt);
                res.cent_y = cbct_pkg::POS_W'(row_sum / mark_cnt);
                n_found++;
            end else begin
                res.cent_x = cbct_pkg::CENTROID_NONE;
                res.cent_y = cbct_pkg::CENTROID_NONE;
            end
            col_pos  = 0;
            row_pos  = 0;
            col_sum  = 0;
            row_sum  = 0;
            mark_cnt = 0;
        end else if (last_col) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // Random pixel; a marker share of mark_pct under the current floor
    function automatic logic [23:0] make_pixel(input int mark_pct);
        int unsigned g, b, r;
        if ($urandom_range(0, 99) < mark_pct && trk_floor < 255) begin
            g = $urandom_range(trk_floor + 1, 255);
            b = $urandom_range(0, (10 * g - 1) / 13);
            r = $urandom_range(0, (10 * g - 1) / 15);
            // now and then sit right on a ratio limit
            if ($urandom_range(0, 3) == 0) b = (10 * g) / 13 + $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0) r = (10 * g) / 15 + $urandom_range(0, 1);
            return {r[7:0], g[7:0], b[7:0]};
        end
        return 24'($urandom);
    endfunction

    // One pixel transfer on s_axis, then its expectation
    task automatic send_pixel(input logic [23:0] px);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_px.push_back(track_pixel(px[7:0], px[15:8], px[23:16]));
    endtask

    // Hold off the sender until every expected output has arrived
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [cbct_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbct_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // Write all four registers; level registers get random unused upper bits
    task automatic set_regs(input logic [cbct_pkg::CFG_W-1:0] cols, rows, floor_lvl, min_px);
        drive_reg(cbct_pkg::CFG_FRAME_COLS, cols);
        drive_reg(cbct_pkg::CFG_FRAME_ROWS, rows);
        drive_reg(cbct_pkg::CFG_GREEN_FLOOR,
                  {4'($urandom), floor_lvl[cbct_pkg::LEVEL_W-1:0]});
        drive_reg(cbct_pkg::CFG_MIN_PIXELS, {4'($urandom), min_px[cbct_pkg::LEVEL_W-1:0]});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        trk_cols  = cols;
        trk_rows  = rows;
        trk_floor = floor_lvl[cbct_pkg::LEVEL_W-1:0];
        trk_min   = min_px[cbct_pkg::LEVEL_W-1:0];
    endtask

    // Default registers, then a width cut below the column counter ends the frame
    task automatic test_shrink_mid_frame();
        repeat (6) send_pixel(make_pixel(60));
        wait_idle();
        set_regs(3, 1, 100, 3);
        send_pixel(make_pixel(60));
        wait_idle();
    endtask

    // Marker test on its limits, one 4x3 frame; pixels are {red, green, blue}
    task automatic test_threshold_edges();
        set_regs(4, 3, 100, 3);
        send_pixel({8'd0,   8'd0,   8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd0,   8'd255, 8'd0});     // marker
        send_pixel({8'd0,   8'd101, 8'd0});     // marker, green just over floor
        send_pixel({8'd0,   8'd100, 8'd0});     // green equals floor
        send_pixel({8'd0,   8'd130, 8'd100});   // blue ratio exactly equal
        send_pixel({8'd0,   8'd130, 8'd99});    // marker
        send_pixel({8'd100, 8'd150, 8'd0});     // red ratio exactly equal
        send_pixel({8'd99,  8'd150, 8'd0});     // marker
        send_pixel({8'd255, 8'd0,   8'd255});
        send_pixel({8'd170, 8'd255, 8'd0});     // red ratio equal at full green
        send_pixel({8'd169, 8'd255, 8'd196});   // marker near both limits
        wait_idle();
    endtask

    // Empty frame with zero minimum, then single-pixel frames from zero sizes
    task automatic test_found_rules();
        set_regs(2, 2, 255, 0);
        send_pixel({8'd0, 8'd255, 8'd0});
        repeat (3) send_pixel(make_pixel(100));
        wait_idle();
        set_regs(0, 0, 0, 1);
        send_pixel({8'd0, 8'd1, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        wait_idle();
    endtask

    // Oversize width, then oversize height on the same frame; a 1x1 size closes it
    task automatic test_size_limits();
        set_regs(4095, 1, 0, 255);
        repeat (24) send_pixel(make_pixel(60));
        wait_idle();
        set_regs(1, 4095, 200, 0);
        repeat (24) send_pixel(make_pixel(30));
        wait_idle();
        set_regs(1, 1, 0, 1);
        send_pixel(make_pixel(50));
        wait_idle();
    endtask

    // Bursts of small frames; each burst ends at a random point, registers change between
    task automatic test_random_bursts(input int n_items);
        int          sent, burst, mark_pct;
        int unsigned cols, rows, floor_lvl;
        sent = 0;
        while (sent < n_items) begin
            cols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            floor_lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(60, 160);
            set_regs(cbct_pkg::CFG_W'(cols), cbct_pkg::CFG_W'(rows),
                     cbct_pkg::CFG_W'(floor_lvl), cbct_pkg::CFG_W'($urandom_range(0, 6)));
            burst = $urandom_range(1, 3 * ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows));
            mark_pct = $urandom_range(0, 90);
            repeat (burst) send_pixel(make_pixel(mark_pct));
            sent += burst;
            wait_idle();
        end
    endtask

    // Output check against the oldest expectation
    always @(posedge i_clk) begin : check_out
        t_px_out want_px, got_px;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_px.blue       = m_axis_tdata[7:0];
            got_px.green      = m_axis_tdata[15:8];
            got_px.red        = m_axis_tdata[23:16];
            got_px.cent_x     = m_axis_tdata[35:24];
            got_px.cent_y     = m_axis_tdata[47:36];
            got_px.frame_done = m_axis_tlast;
            got_px.found      = m_axis_tuser;
            if (expected_px.size() == 0) begin
                errors++;
                $display("%0t: output with nothing expected: tdata=%h last=%b user=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want_px = expected_px.pop_front();
                if (got_px !== want_px) begin
                    errors++;
                    $display("%0t: expected b=%0d g=%0d r=%0d last=%b found=%b x=%0d y=%0d",
                             $time, want_px.blue, want_px.green, want_px.red,
                             want_px.frame_done, want_px.found,
                             $signed(want_px.cent_x), $signed(want_px.cent_y));
                    $display("%0t:   actual b=%0d g=%0d r=%0d last=%b found=%b x=%0d y=%0d",
                             $time, got_px.blue, got_px.green, got_px.red,
                             got_px.frame_done, got_px.found,
                             $signed(got_px.cent_x), $signed(got_px.cent_y));
                end
            end
        end
    end

    initial begin
        trk_cols  = cbct_pkg::RST_FRAME_COLS;
        trk_rows  = cbct_pkg::RST_FRAME_ROWS;
        trk_floor = cbct_pkg::RST_GREEN_FLOOR;
        trk_min   = cbct_pkg::RST_MIN_PIXELS;
        col_pos   = 0;
        row_pos   = 0;
        mark_cnt  = 0;
        col_sum   = 0;
        row_sum   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_shrink_mid_frame();
        test_threshold_edges();
        test_found_rules();
        test_size_limits();

        // random traffic under each flow-control mix
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_bursts(180);
        send_idle_pct = 48; recv_stall_pct = 0;
        test_random_bursts(180);
        send_idle_pct = 0;  recv_stall_pct = 48;
        test_random_bursts(180);
        send_idle_pct = 38; recv_stall_pct = 38;
        test_random_bursts(180);

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d pixels, %0d of them marker pixels, in %0d frames (%0d found)",
                 n_pixels, n_markers, n_frames, n_found);
        $display("under four stall mixes, with threshold edges and oversize sizes; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("%0t: timeout with %0d outputs outstanding", $time, expected_px.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
